/* rtl/core/toi_pkg.sv */
// Shared types, register codes and the thermistor conversion table for the
// over-temperature interlock. No dependencies.
package toi_pkg;

    localparam int CHANNELS         = 6;
    localparam int CRANIAL_CHANNELS = 5;
    localparam int TABLE_TOP        = 110;

    typedef logic [11:0] t_count;
    typedef logic [6:0]  t_degree;
    typedef logic [15:0] t_mask;
    typedef logic [7:0]  t_slot;

    // Configuration register indexes (word address bits [3:2])
    localparam logic [1:0] REG_CUTOFF  = 2'd0;
    localparam logic [1:0] REG_REARM   = 2'd1;
    localparam logic [1:0] REG_CRANIAL = 2'd2;
    localparam logic [1:0] REG_HUBCODE = 2'd3;

    localparam t_degree CUTOFF_RST  = 7'd62;
    localparam t_degree REARM_RST   = 7'd55;
    localparam t_mask   CRANIAL_RST = 16'h0001;
    localparam t_slot   HUBCODE_RST = 8'hFF;

    // Descending ADC thresholds, entry t is the lowest count still read as t degrees
    localparam t_count NTC_THRESH [0:TABLE_TOP] = '{
        12'd3820, 12'd3800, 12'd3775, 12'd3750, 12'd3720, 12'd3690, 12'd3655,
        12'd3620, 12'd3580, 12'd3540, 12'd3495, 12'd3448, 12'd3398, 12'd3346,
        12'd3290, 12'd3232, 12'd3170, 12'd3107, 12'd3040, 12'd2972, 12'd2901,
        12'd2829, 12'd2756, 12'd2680, 12'd2604, 12'd2527, 12'd2450, 12'd2372,
        12'd2294, 12'd2217, 12'd2140, 12'd2065, 12'd1990, 12'd1917, 12'd1846,
        12'd1776, 12'd1708, 12'd1641, 12'd1577, 12'd1515, 12'd1455, 12'd1397,
        12'd1342, 12'd1289, 12'd1238, 12'd1189, 12'd1143, 12'd1099, 12'd1057,
        12'd1017, 12'd979,  12'd943,  12'd909,  12'd877,  12'd846,  12'd817,
        12'd789,  12'd763,  12'd738,  12'd714,  12'd692,  12'd670,  12'd650,
        12'd631,  12'd612,  12'd595,  12'd578,  12'd562,  12'd547,  12'd532,
        12'd519,  12'd505,  12'd493,  12'd481,  12'd469,  12'd458,  12'd447,
        12'd437,  12'd427,  12'd417,  12'd408,  12'd399,  12'd390,  12'd382,
        12'd374,  12'd366,  12'd359,  12'd352,  12'd345,  12'd338,  12'd332,
        12'd326,  12'd320,  12'd314,  12'd308,  12'd303,  12'd298,  12'd293,
        12'd288,  12'd283,  12'd278,  12'd274,  12'd270,  12'd265,  12'd261,
        12'd257,  12'd254,  12'd250,  12'd246,  12'd243,  12'd239
    };

    // Comparator bank against every constant entry from 1 up; the lowest matching
    // entry wins, and a count below the last entry reads as the top degree.
    function automatic t_degree count_to_degree(t_count count);
        t_degree deg;
        deg = 7'(TABLE_TOP);
        for (int t = TABLE_TOP; t >= 1; t--) begin
            if (count >= NTC_THRESH[t]) begin
                deg = 7'(t);
            end
        end
        count_to_degree = deg;
    endfunction

endpackage

/* rtl/core/thermistor_overtemp_interlock_core.sv */
// Top level of the thermistor over-temperature interlock: input word register,
// per-channel conversion and trip logic, result register and APB registers.
// Depends on toi_pkg.

// One word is one poll: five cranial thermistor counts, one hub count and the
// current enable mask. The block takes a word every cycle while o_stall is low
// and returns one result word per accepted word, via the input and result registers.
// Each count goes through a bank of constant compares against the fixed
// conversion table and a priority pick of the lowest matching entry, one bank
// per channel, all between the input register and the result register; that
// compare bank plus the compare against cutoff and re-arm sets the cycle time.
// A channel trips when its temperature reaches cutoff_degrees while
// unlatched and re-arms at or below rearm_degrees. A cranial trip clears the
// cranial_enable_bits from the mask, a hub trip zeroes the mask. The trip code
// output gives the highest newly tripped cranial index, or hub_fault_code when
// the hub tripped. The trip latches update as a word moves into the result
// register, so back-to-back polls see each other's latches in order. Write the
// APB registers only while no word is in flight; reads are always available.
module thermistor_overtemp_interlock_core
    import toi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_reading_0,
    input  logic [11:0] i_reading_1,
    input  logic [11:0] i_reading_2,
    input  logic [11:0] i_reading_3,
    input  logic [11:0] i_reading_4,
    input  logic [11:0] i_reading_hub,
    input  logic [15:0] i_mask_in,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_mask_out,
    output logic        o_fault_valid,
    output logic [7:0]  o_trip_code,
    output logic        o_raise_thermal_cutoff,
    output logic        o_any_latched,
    output logic [5:0]  o_latch_bits,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_degree r_cutoff;
    t_degree r_rearm;
    t_mask   r_cranial;
    t_slot   r_hubcode;

    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff  <= CUTOFF_RST;
            r_rearm   <= REARM_RST;
            r_cranial <= CRANIAL_RST;
            r_hubcode <= HUBCODE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_CUTOFF:  r_cutoff  <= pwdata[6:0];
                REG_REARM:   r_rearm   <= pwdata[6:0];
                REG_CRANIAL: r_cranial <= pwdata[15:0];
                REG_HUBCODE: r_hubcode <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CUTOFF:  prdata = {25'd0, r_cutoff};
            REG_REARM:   prdata = {25'd0, r_rearm};
            REG_CRANIAL: prdata = {16'd0, r_cranial};
            REG_HUBCODE: prdata = {24'd0, r_hubcode};
            default:     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Handshake: input word register feeding the result register
    // ---------------------------------------------------------------
    logic   r_in_valid;
    logic   r_out_valid;
    t_count r_reading [CHANNELS];
    t_mask  r_mask_in;

    logic w_in_accept;
    logic w_advance;

    // Move the held word on when the result register is empty or being drained.
    assign w_advance   = r_in_valid & (~r_out_valid | ~i_stall);
    assign o_stall     = r_in_valid & r_out_valid & i_stall;
    assign w_in_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the poll; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_reading[0] <= i_reading_0;
            r_reading[1] <= i_reading_1;
            r_reading[2] <= i_reading_2;
            r_reading[3] <= i_reading_3;
            r_reading[4] <= i_reading_4;
            r_reading[5] <= i_reading_hub;
            r_mask_in    <= i_mask_in;
        end
    end

    // ---------------------------------------------------------------
    // Per-channel conversion, trip and re-arm
    // ---------------------------------------------------------------
    logic [CHANNELS-1:0] r_trip;
    logic [CHANNELS-1:0] n_trip;
    logic [CHANNELS-1:0] w_new_trip;
    t_degree             w_degree [CHANNELS];

    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            w_degree[ch]   = count_to_degree(r_reading[ch]);
            // Trip test wins over re-arm for an unlatched channel.
            w_new_trip[ch] = (w_degree[ch] >= r_cutoff) & ~r_trip[ch];
            n_trip[ch]     = w_new_trip[ch]
                           | (r_trip[ch] & ~(w_degree[ch] <= r_rearm));
        end
    end

    // Mask cut and trip code; the hub channel sits above the cranial ones, and a
    // hub trip always owns the code.
    t_mask n_mask_out;
    t_slot n_trip_code;
    logic  w_cranial_trip;
    logic  w_hub_trip;

    assign w_cranial_trip = |w_new_trip[CRANIAL_CHANNELS-1:0];
    assign w_hub_trip     = |w_new_trip[CHANNELS-1:CRANIAL_CHANNELS];

    always_comb begin
        n_trip_code = '0;
        for (int ch = 0; ch < CRANIAL_CHANNELS; ch++) begin
            if (w_new_trip[ch]) begin
                n_trip_code = 8'(ch);
            end
        end
        if (w_hub_trip) begin
            n_trip_code = r_hubcode;
        end

        if (w_hub_trip) begin
            n_mask_out = '0;
        end else if (w_cranial_trip) begin
            n_mask_out = r_mask_in & ~r_cranial;
        end else begin
            n_mask_out = r_mask_in;
        end
    end

    // ---------------------------------------------------------------
    // Result register and trip latches
    // ---------------------------------------------------------------
    t_mask r_mask_out;
    t_slot r_trip_code;
    logic  r_fault;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_trip      <= '0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            r_trip      <= n_trip;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_mask_out  <= n_mask_out;
            r_trip_code <= n_trip_code;
            r_fault     <= w_cranial_trip | w_hub_trip;
        end
    end

    // Latches only move on an advance, so they still describe the held result.
    assign o_valid                = r_out_valid;
    assign o_mask_out             = r_mask_out;
    assign o_fault_valid          = r_fault;
    assign o_trip_code            = r_trip_code;
    assign o_raise_thermal_cutoff = r_fault;
    assign o_latch_bits           = r_trip;
    assign o_any_latched          = |r_trip;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fault_sets_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault_valid |-> o_latch_bits != '0)
        else $error("fault reported with no trip latch set");

    a_no_trip_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_fault_valid |-> o_trip_code == '0)
        else $error("trip code nonzero without a new trip");

    a_latch_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_trip))
        else $error("trip latches moved without a word advancing");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free pipeline");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for thermistor_overtemp_interlock_core: directed polls,
// then random temperature walks under several trip settings. Depends on toi_pkg.
module testbench
    import toi_pkg::*;
();

    // One poll word as driven on the input channel.
    typedef struct packed {
        t_count r0;
        t_count r1;
        t_count r2;
        t_count r3;
        t_count r4;
        t_count hub;
        t_mask  mask;
    } t_poll;

    // One verdict word as seen on the result channel.
    typedef struct packed {
        t_mask      mask_out;
        logic       fault_valid;
        t_slot      trip_code;
        logic       raise_cutoff;
        logic       any_latched;
        logic [5:0] latch_bits;
    } t_verdict;

    // Directed row: the poll and, where typed, the verdict it must produce.
    typedef struct packed {
        t_poll    poll;
        logic     typed;
        t_verdict want;
    } t_poll_row;

    localparam t_count COLD = 12'd4095;    // reads as 1 degree
    localparam t_count HOT  = 12'd0;       // reads as 110 degrees
    localparam int     DIRECTED_ROWS = 18;
    localparam int     PHASE_POLLS   = 250;
    localparam int     PHASES        = 6;

    // Starting from reset settings: cutoff 62, re-arm 55, cranial bits 0x0001,
    // hub code 0xFF. Rows with typed = 0 are checked against the predictor.
    localparam t_poll_row DIRECTED [DIRECTED_ROWS] = '{
        '{'{COLD, COLD, COLD, COLD, COLD, COLD, 16'hFFFF}, 1'b1,
          '{16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0, 6'h00}},
        // every channel trips at once: hub wins the code and zeroes the mask
        '{'{HOT, HOT, HOT, HOT, HOT, HOT, 16'hFFFF}, 1'b1,
          '{16'h0000, 1'b1, 8'hFF, 1'b1, 1'b1, 6'h3F}},
        '{'{COLD, COLD, COLD, COLD, COLD, COLD, 16'hFFFF}, 1'b1,
          '{16'hFFFF, 1'b0, 8'h00, 1'b0, 1'b0, 6'h00}},
        '{'{COLD, COLD, HOT, COLD, COLD, COLD, 16'hFFFF}, 1'b1,
          '{16'hFFFE, 1'b1, 8'h02, 1'b1, 1'b1, 6'h04}},
        // already latched: no new trip, mask passes through
        '{'{COLD, COLD, HOT, COLD, COLD, COLD, 16'hAAAA}, 1'b1,
          '{16'hAAAA, 1'b0, 8'h00, 1'b0, 1'b1, 6'h04}},
        '{'{COLD, COLD, COLD, COLD, COLD, COLD, 16'h0000}, 1'b1,
          '{16'h0000, 1'b0, 8'h00, 1'b0, 1'b0, 6'h00}},
        // cutoff edges: 670 reads 61, 650 and 669 read 62
        '{'{12'd670, 12'd650, COLD, 12'd669, COLD, COLD, 16'hFFFF}, 1'b0, '0},
        // re-arm edges: 789 reads 56 (stays), 817 reads 55 (re-arms)
        '{'{COLD, 12'd789, COLD, 12'd817, COLD, COLD, 16'h0F0F}, 1'b0, '0},
        // table ends: top entry, second entry, last entries
        '{'{12'd3820, 12'd3799, COLD, COLD, 12'd242, 12'd243, 16'hFFFF}, 1'b0, '0},
        '{'{COLD, COLD, COLD, COLD, 12'd239, 12'd238, 16'h1234}, 1'b0, '0},
        '{'{COLD, COLD, COLD, COLD, COLD, COLD, 16'h8001}, 1'b0, '0},
        '{'{COLD, COLD, COLD, COLD, COLD, HOT, 16'h1234}, 1'b1,
          '{16'h0000, 1'b1, 8'hFF, 1'b1, 1'b1, 6'h20}},
        '{'{COLD, COLD, COLD, COLD, COLD, COLD, 16'h5555}, 1'b1,
          '{16'h5555, 1'b0, 8'h00, 1'b0, 1'b0, 6'h00}},
        // all cranial domains trip together: highest index takes the code
        '{'{HOT, HOT, HOT, HOT, HOT, COLD, 16'hFFFF}, 1'b1,
          '{16'hFFFE, 1'b1, 8'h04, 1'b1, 1'b1, 6'h1F}},
        '{'{12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 16'hA5A5}, 1'b0, '0},
        '{'{12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'hAAA, 16'h5A5A}, 1'b0, '0},
        '{'{12'd254, 12'd257, 12'd261, 12'd246, 12'd250, HOT, 16'hFFFF}, 1'b0, '0},
        '{'{COLD, COLD, COLD, COLD, COLD, COLD, 16'hFFFF}, 1'b0, '0}
    };

    // Lowest ADC count still read as entry t degrees (entry 0 is unused).
    localparam int NTC_STEPS [0:110] = '{
        3820, 3800, 3775, 3750, 3720, 3690, 3655, 3620, 3580, 3540,
        3495, 3448, 3398, 3346, 3290, 3232, 3170, 3107, 3040, 2972,
        2901, 2829, 2756, 2680, 2604, 2527, 2450, 2372, 2294, 2217,
        2140, 2065, 1990, 1917, 1846, 1776, 1708, 1641, 1577, 1515,
        1455, 1397, 1342, 1289, 1238, 1189, 1143, 1099, 1057, 1017,
         979,  943,  909,  877,  846,  817,  789,  763,  738,  714,
         692,  670,  650,  631,  612,  595,  578,  562,  547,  532,
         519,  505,  493,  481,  469,  458,  447,  437,  427,  417,
         408,  399,  390,  382,  374,  366,  359,  352,  345,  338,
         332,  326,  320,  314,  308,  303,  298,  293,  288,  283,
         278,  274,  270,  265,  261,  257,  254,  250,  246,  243,  239
    };

    // DUT ports, all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_count      i_reading_0 = '0;
    t_count      i_reading_1 = '0;
    t_count      i_reading_2 = '0;
    t_count      i_reading_3 = '0;
    t_count      i_reading_4 = '0;
    t_count      i_reading_hub = '0;
    t_mask       i_mask_in = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_mask_out;
    logic        o_fault_valid;
    logic [7:0]  o_trip_code;
    logic        o_raise_thermal_cutoff;
    logic        o_any_latched;
    logic [5:0]  o_latch_bits;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the settings and trip latches
    int unsigned cfg_cutoff  = 62;
    int unsigned cfg_rearm   = 55;
    t_mask       cfg_cranial = 16'h0001;
    t_slot       cfg_hubcode = 8'hFF;
    logic [5:0]  trip_state  = '0;

    t_verdict    pending_verdicts [$];
    int          polls_sent   = 0;
    int          words_out    = 0;
    int          mismatches   = 0;
    int          holdoff_left = 0;
    bit          holdoff_done = 1'b0;
    int          chan_deg [CHANNELS];

    thermistor_overtemp_interlock_core dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_reading_0            (i_reading_0),
        .i_reading_1            (i_reading_1),
        .i_reading_2            (i_reading_2),
        .i_reading_3            (i_reading_3),
        .i_reading_4            (i_reading_4),
        .i_reading_hub          (i_reading_hub),
        .i_mask_in              (i_mask_in),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_mask_out             (o_mask_out),
        .o_fault_valid          (o_fault_valid),
        .o_trip_code            (o_trip_code),
        .o_raise_thermal_cutoff (o_raise_thermal_cutoff),
        .o_any_latched          (o_any_latched),
        .o_latch_bits           (o_latch_bits),
        .psel                   (psel),
        .penable                (penable),
        .pwrite                 (pwrite),
        .paddr                  (paddr),
        .pwdata                 (pwdata),
        .prdata                 (prdata),
        .pready                 (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest passing run.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Walk the table from the cold side up; counts below the last entry
    // and at or above the second entry saturate to 110 and 1.
    function automatic int adc_to_degree(input t_count count);
        for (int t = 1; t <= 110; t++) begin
            if (int'(count) >= NTC_STEPS[t]) return t;
        end
        return 110;
    endfunction

    // Pick a random count that reads back as the given degree.
    function automatic t_count count_in_degree(input int deg);
        int lo;
        int hi;
        lo = (deg >= 110) ? 0 : NTC_STEPS[deg];
        hi = (deg <= 1) ? 4095 : NTC_STEPS[deg - 1] - 1;
        return t_count'($urandom_range(hi, lo));
    endfunction

    // Advance the trip latches for one poll and form its verdict. Trip test
    // comes first, so an unlatched channel that also meets re-arm still trips.
    function automatic t_verdict interlock_predict(input t_poll p);
        t_count   cnt [CHANNELS];
        t_verdict v;
        int       deg;
        cnt[0] = p.r0;
        cnt[1] = p.r1;
        cnt[2] = p.r2;
        cnt[3] = p.r3;
        cnt[4] = p.r4;
        cnt[5] = p.hub;
        v = '0;
        v.mask_out = p.mask;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            deg = adc_to_degree(cnt[ch]);
            if (deg >= cfg_cutoff && !trip_state[ch]) begin
                trip_state[ch] = 1'b1;
                v.fault_valid = 1'b1;
                if (ch < CRANIAL_CHANNELS) begin
                    v.mask_out = v.mask_out & ~cfg_cranial;
                    v.trip_code = t_slot'(ch);
                end else begin
                    v.mask_out = '0;
                    v.trip_code = cfg_hubcode;
                end
            end else if (deg <= cfg_rearm && trip_state[ch]) begin
                trip_state[ch] = 1'b0;
            end
        end
        v.raise_cutoff = v.fault_valid;
        v.latch_bits = trip_state;
        v.any_latched = |trip_state;
        return v;
    endfunction

    // Random poll: mostly a temperature walk per channel, some jumps into the band
    // from re-arm minus 4 to cutoff plus 4, some raw counts as noise.
    function automatic t_poll random_poll();
        t_poll  p;
        t_count cnt [CHANNELS];
        int     lo;
        int     hi;
        int     pick;
        lo = int'(cfg_rearm) - 4;
        hi = int'(cfg_cutoff) + 4;
        if (lo < 1) lo = 1;
        if (lo > 110) lo = 110;
        if (hi < 1) hi = 1;
        if (hi > 110) hi = 110;
        if (lo > hi) begin
            pick = lo;
            lo = hi;
            hi = pick;
        end
        for (int ch = 0; ch < CHANNELS; ch++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                cnt[ch] = t_count'($urandom_range(4095));
            end else begin
                if (pick < 30) begin
                    chan_deg[ch] = $urandom_range(hi, lo);
                end else begin
                    chan_deg[ch] = chan_deg[ch] + $urandom_range(8) - 4;
                end
                if (chan_deg[ch] < 1) chan_deg[ch] = 1;
                if (chan_deg[ch] > 110) chan_deg[ch] = 110;
                cnt[ch] = count_in_degree(chan_deg[ch]);
            end
        end
        p.r0 = cnt[0];
        p.r1 = cnt[1];
        p.r2 = cnt[2];
        p.r3 = cnt[3];
        p.r4 = cnt[4];
        p.hub = cnt[5];
        p.mask = t_mask'($urandom_range(16'hFFFF));
        return p;
    endfunction

    // Offer one poll word, idle at random before it, hold it until accepted,
    // then queue what it must produce. Leaves i_valid high on return.
    task automatic send_poll(input t_poll p, input logic typed, input t_verdict want);
        t_verdict predicted;
        // no sender gaps inside the steady window
        while (!(polls_sent >= 800 && polls_sent < 1100) && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_reading_0   <= p.r0;
        i_reading_1   <= p.r1;
        i_reading_2   <= p.r2;
        i_reading_3   <= p.r3;
        i_reading_4   <= p.r4;
        i_reading_hub <= p.hub;
        i_mask_in     <= p.mask;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = interlock_predict(p);
        pending_verdicts.push_back(typed ? want : predicted);
        polls_sent++;
    endtask

    // APB write: setup cycle, access cycle, register lands when pready is high.
    task automatic write_reg(input logic [1:0] idx, input int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CUTOFF:  cfg_cutoff  = value & 32'h7F;
            REG_REARM:   cfg_rearm   = value & 32'h7F;
            REG_CRANIAL: cfg_cranial = t_mask'(value);
            REG_HUBCODE: cfg_hubcode = t_slot'(value);
            default: ;
        endcase
    endtask

    // Drain all verdicts, let the pipeline settle, then load a new setting.
    task automatic load_settings(input int unsigned cutoff, input int unsigned rearm,
                                 input int unsigned cranial, input int unsigned hubcode);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(REG_CUTOFF, cutoff);
        write_reg(REG_REARM, rearm);
        write_reg(REG_CRANIAL, cranial);
        write_reg(REG_HUBCODE, hubcode);
    endtask

    // Compare the accepted verdict word against the oldest expectation.
    task automatic check_verdict();
        t_verdict want;
        if (pending_verdicts.size() == 0) begin
            $error("verdict word with none expected: mask_out %h code %h",
                   o_mask_out, o_trip_code);
            mismatches++;
            return;
        end
        want = pending_verdicts.pop_front();
        if (o_mask_out !== want.mask_out) begin
            $error("mask_out: expected %h, got %h", want.mask_out, o_mask_out);
            mismatches++;
        end
        if (o_fault_valid !== want.fault_valid) begin
            $error("fault_valid: expected %b, got %b", want.fault_valid, o_fault_valid);
            mismatches++;
        end
        if (o_trip_code !== want.trip_code) begin
            $error("trip_code: expected %h, got %h", want.trip_code, o_trip_code);
            mismatches++;
        end
        if (o_raise_thermal_cutoff !== want.raise_cutoff) begin
            $error("raise_thermal_cutoff: expected %b, got %b",
                   want.raise_cutoff, o_raise_thermal_cutoff);
            mismatches++;
        end
        if (o_any_latched !== want.any_latched) begin
            $error("any_latched: expected %b, got %b", want.any_latched, o_any_latched);
            mismatches++;
        end
        if (o_latch_bits !== want.latch_bits) begin
            $error("latch_bits: expected %h, got %h", want.latch_bits, o_latch_bits);
            mismatches++;
        end
    endtask

    // Result side: check each accepted word, then pick next cycle's stall.
    // Once, after 300 words, hold the stall high so the block backs up
    // and stalls its input; never stall inside the steady window.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_verdict();
            words_out++;
        end
        if (words_out == 300 && !holdoff_done) begin
            holdoff_left = 300;
            holdoff_done = 1'b1;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_stall <= 1'b1;
        end else if (words_out >= 800 && words_out < 1100) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 25);
        end
    end

    // Main sequence: reset, directed rows at reset settings, then random
    // phases, each under its own setting, extremes included.
    initial begin
        int unsigned cut;
        for (int ch = 0; ch < CHANNELS; ch++) chan_deg[ch] = $urandom_range(110, 1);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            send_poll(DIRECTED[row].poll, DIRECTED[row].typed, DIRECTED[row].want);
        end
        i_valid <= 1'b0;

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_settings(62, 55, 16'h0001, 8'hFF);
                1: load_settings(40, 30, 16'hFFFF, 8'h00);
                // trip and re-arm met together at 110
                2: load_settings(110, 110, 16'h0000, $urandom_range(255));
                // every unlatched channel trips, every latched one re-arms
                3: load_settings(0, 127, $urandom_range(16'hFFFF), 8'h80);
                // cutoff out of the table's reach: nothing trips
                4: load_settings(127, 0, $urandom_range(16'hFFFF), 8'h5A);
                default: begin
                    cut = $urandom_range(109, 2);
                    load_settings(cut, $urandom_range(cut - 1, 1),
                                  $urandom_range(16'hFFFF), $urandom_range(255));
                end
            endcase
            @(posedge i_clk);
            for (int n = 0; n < PHASE_POLLS; n++) begin
                send_poll(random_poll(), 1'b0, '0);
            end
            i_valid <= 1'b0;
        end

        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/toi_pkg.sv
rtl/core/thermistor_overtemp_interlock_core.sv
tb/testbench.sv
